@@ rtl/bgc_pkg.sv @@
// Package: shared types and constants for the button gesture classifier.
package bgc_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] TICK_SAT = {TICK_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    localparam logic [TICK_W-1:0] WINDOW_RST = 16'd300;
    localparam logic [TICK_W-1:0] LONG_RST = 16'd1000;
    localparam logic [TICK_W-1:0] HOLD_RST = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_ONE = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;

    typedef enum logic [2:0] {
        GEST_SINGLE = 3'd0,
        GEST_DOUBLE = 3'd1,
        GEST_TRIPLE = 3'd2,
        GEST_LONG = 3'd3,
        GEST_HOLD = 3'd4
    } t_gesture;

    typedef struct packed {
        logic [TICK_W-1:0] multi_press_window;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] hold_delay_ticks;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        t_gesture gesture;
    } t_result;

endpackage

@@ rtl/bgc_if.sv @@
// Interfaces: input, result and configuration channels of the gesture classifier.
interface bgc_in_if;
    logic valid;
    logic ready;
    logic button_down;

    modport source (output valid, output button_down, input ready);
    modport sink (input valid, input button_down, output ready);
endinterface

interface bgc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink (input valid, input gesture, output ready);
endinterface

interface bgc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/bgc_cfg_regs.sv @@
// Configuration register file: window, long-press and hold thresholds.
module bgc_cfg_regs
    import bgc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bgc_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IDX_WINDOW: n_cfg.multi_press_window = i_cfg.data;
                CFG_IDX_LONG:   n_cfg.long_press_ticks = i_cfg.data;
                CFG_IDX_HOLD:   n_cfg.hold_delay_ticks = i_cfg.data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.multi_press_window <= WINDOW_RST;
            r_cfg.long_press_ticks <= LONG_RST;
            r_cfg.hold_delay_ticks <= HOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bgc_classify.sv @@
// Gesture state and per-tick classification from one registered button sample.
module bgc_classify
    import bgc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_down,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic               r_held,          n_held;
    logic [TICK_W-1:0]  r_press_ticks,   n_press_ticks;
    logic [COUNT_W-1:0] r_press_count,   n_press_count;
    logic [TICK_W-1:0]  r_window_left,   n_window_left;
    logic               r_window_active, n_window_active;
    t_result            res;

    always_comb begin
        n_held = r_held;
        n_press_ticks = r_press_ticks;
        n_press_count = r_press_count;
        n_window_left = r_window_left;
        n_window_active = r_window_active;
        res.valid = 1'b0;
        res.gesture = GEST_SINGLE;

        // press length keeps counting through the release tick
        if (r_held && r_press_ticks != TICK_SAT) begin
            n_press_ticks = r_press_ticks + 1'b1;
        end

        if (i_down) begin
            if (!r_held) begin
                n_held = 1'b1;
                n_press_ticks = '0;
                if (r_press_count != COUNT_SAT) begin
                    n_press_count = r_press_count + 1'b1;
                end
                n_window_active = 1'b0;
                n_window_left = '0;
            end
            if (n_press_ticks >= i_cfg.hold_delay_ticks) begin
                res.valid = 1'b1;
                res.gesture = GEST_HOLD;
            end
        end else if (r_held) begin
            n_held = 1'b0;
            if (n_press_ticks < i_cfg.long_press_ticks) begin
                n_window_left = i_cfg.multi_press_window;
                n_window_active = 1'b1;
            end else begin
                n_press_count = '0;
                n_window_active = 1'b0;
                n_window_left = '0;
                res.valid = 1'b1;
                res.gesture = GEST_LONG;
            end
        end else if (r_window_active) begin
            if (r_window_left != '0) begin
                n_window_left = r_window_left - 1'b1;
            end else begin
                // window expired: report a count of one to three and drop the count
                n_window_active = 1'b0;
                n_press_count = '0;
                case (r_press_count)
                    COUNT_ONE: begin
                        res.valid = 1'b1;
                        res.gesture = GEST_SINGLE;
                    end
                    COUNT_TWO: begin
                        res.valid = 1'b1;
                        res.gesture = GEST_DOUBLE;
                    end
                    COUNT_THREE: begin
                        res.valid = 1'b1;
                        res.gesture = GEST_TRIPLE;
                    end
                    default: res.valid = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_press_ticks <= '0;
            r_press_count <= '0;
            r_window_left <= '0;
            r_window_active <= 1'b0;
        end else if (i_step) begin
            r_held <= n_held;
            r_press_ticks <= n_press_ticks;
            r_press_count <= n_press_count;
            r_window_left <= n_window_left;
            r_window_active <= n_window_active;
        end
    end

    assign o_result.valid = i_step && res.valid;
    assign o_result.gesture = res.gesture;

endmodule

@@ rtl/button_gesture_classifier_core.sv @@
// Top level: input register, classification logic and result register.
// A result word is formed from an input word held in the input register and is kept in the result register.
// Throughput: one input word per cycle; the result register lets input flow
// while a finished word waits, and input stalls only when that word is not taken.
// Reset (synchronous, active low) clears all gesture state and pipeline valids
// and loads the thresholds with 300, 1000 and 2000 ticks.
module button_gesture_classifier_core
    import bgc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bgc_in_if.sink    i_in,
    bgc_out_if.source o_out,
    bgc_cfg_if.sink   i_cfg
);

    t_cfg     cfg;
    t_result  result;
    logic     r_in_valid;
    logic     r_in_down;
    logic     r_out_valid;
    t_gesture r_gesture;
    logic     out_free;
    logic     advance;

    bgc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // the result register is free when empty or being emptied this cycle
    assign out_free = !r_out_valid || o_out.ready;
    assign advance = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    bgc_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_down   (r_in_down),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_down <= i_in.button_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_gesture <= result.gesture;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.gesture = r_gesture;

endmodule
